// File: sv/ledfl_pkg.sv
// Shared constants, command codes and controller/datapath link types for the LED flasher.
package ledfl_pkg;

  // Channel count in use and the fixed size of the channel table
  localparam int NUM_CHANNELS = 8;
  localparam int MAX_CHANNELS = 8;

  // Input function codes
  localparam logic [1:0] FUNC_ON     = 2'd0;
  localparam logic [1:0] FUNC_OFF    = 2'd1;
  localparam logic [1:0] FUNC_FLASH  = 2'd2;
  localparam logic [1:0] FUNC_UPDATE = 2'd3;

  // Channel mode codes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_ON    = 2'd1;
  localparam logic [1:0] MODE_OFF   = 2'd2;
  localparam logic [1:0] MODE_FLASH = 2'd3;

  // Saturation limit of the remaining toggle count
  localparam logic [14:0] CNT_MAX = 15'h7FFF;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       cmd_we;     // apply an on, off or flash command beat
    logic       upd_start;  // an update beat was taken: latch time and force
    logic       walk_en;    // process one channel entry this cycle
    logic [2:0] walk_idx;   // channel entry being processed
    logic       finish;     // close the update: commit pattern, load result
  } ledfl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic finish_hold;      // result due but the output register is still full
  } ledfl_stat_t;

endpackage

// File: sv/ledfl_ctrl.sv
// Controller state machine: takes input beats and sequences the channel walk.
module ledfl_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_func,
  input  ledfl_pkg::ledfl_stat_t stat,
  output logic                  in_stall,
  output ledfl_pkg::ledfl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [2:0] LAST_IDX = 3'(ledfl_pkg::NUM_CHANNELS - 1);

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic [2:0] idx_r;
  logic [2:0] idx_nxt;
  logic       accept;

  // Decode handshake and issue datapath commands
  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    accept        = in_valid && !in_stall;
    cmd.cmd_we    = accept && (in_func != ledfl_pkg::FUNC_UPDATE);
    cmd.upd_start = accept && (in_func == ledfl_pkg::FUNC_UPDATE);
    cmd.walk_en   = (state_r == ST_WALK);
    cmd.walk_idx  = idx_r;
    cmd.finish    = (state_r == ST_DONE) && !stat.finish_hold;
  end

  // Advance the walk one channel a cycle, then close the update
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.upd_start) begin
          state_nxt = ST_WALK;
          idx_nxt   = 3'd0;
        end
      end
      ST_WALK: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      ST_DONE: begin
        if (!stat.finish_hold) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// File: sv/ledfl_dp.sv
// Datapath: channel table, flash timer arithmetic, pattern and output register.
module ledfl_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ledfl_pkg::ledfl_cmd_t  cmd,
  input  logic [1:0]            in_func,
  input  logic [2:0]            in_channel,
  input  logic [14:0]           in_flash_period,
  input  logic                  in_start_level,
  input  logic [14:0]           in_repeat_count,
  input  logic [31:0]           in_now_ms,
  input  logic                  in_force_output,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [7:0]            out_led_pattern,
  output ledfl_pkg::ledfl_stat_t stat
);

  // Channel table
  logic [1:0]  mode_r   [ledfl_pkg::MAX_CHANNELS];
  logic        level_r  [ledfl_pkg::MAX_CHANNELS];
  logic [31:0] start_r  [ledfl_pkg::MAX_CHANNELS];
  logic [14:0] period_r [ledfl_pkg::MAX_CHANNELS];
  logic [14:0] rem_r    [ledfl_pkg::MAX_CHANNELS];

  // Update context and pattern
  logic [31:0] now_r;
  logic        force_r;
  logic [7:0]  shown_r;
  logic [7:0]  work_r;
  logic [7:0]  work_nxt;
  logic        out_valid_r;
  logic [7:0]  out_pat_r;

  // Selected entry and its next value
  logic [2:0]  addr;
  logic        in_rng;
  logic        entry_we;
  logic [1:0]  cur_mode;
  logic        cur_level;
  logic [31:0] cur_start;
  logic [14:0] cur_period;
  logic [14:0] cur_rem;
  logic [31:0] start_eff;
  logic [31:0] elapsed;
  logic        due;
  logic [14:0] rem_dec;
  logic [15:0] rem_sum;
  logic [14:0] rem_sat;
  logic [7:0]  chan_bit;
  logic [1:0]  mode_nxt;
  logic        level_nxt;
  logic [31:0] start_nxt;
  logic [14:0] period_nxt;
  logic [14:0] rem_nxt;
  logic        emit;

  // Pick the entry: walk index during an update, else the command channel
  always_comb begin
    addr       = cmd.walk_en ? cmd.walk_idx : in_channel;
    in_rng     = ({1'b0, in_channel} < 4'(ledfl_pkg::NUM_CHANNELS));
    cur_mode   = mode_r[addr];
    cur_level  = level_r[addr];
    cur_start  = start_r[addr];
    cur_period = period_r[addr];
    cur_rem    = rem_r[addr];
  end

  // Timer and counter arithmetic for the selected entry
  always_comb begin
    start_eff = (cur_start == 32'd0) ? now_r : cur_start;
    elapsed   = now_r - start_eff;
    due       = (elapsed > {17'd0, cur_period});
    rem_dec   = (cur_rem != 15'd0) ? (cur_rem - 15'd1) : cur_rem;
    rem_sum   = {1'b0, cur_rem} + {1'b0, in_repeat_count};
    rem_sat   = rem_sum[15] ? ledfl_pkg::CNT_MAX : rem_sum[14:0];
    chan_bit  = 8'b1 << cmd.walk_idx;
  end

  // Apply a command beat or advance one channel of the walk
  always_comb begin
    mode_nxt   = cur_mode;
    level_nxt  = cur_level;
    start_nxt  = cur_start;
    period_nxt = cur_period;
    rem_nxt    = cur_rem;
    work_nxt   = work_r;
    entry_we   = cmd.walk_en || (cmd.cmd_we && in_rng);
    if (cmd.walk_en) begin
      case (cur_mode)
        ledfl_pkg::MODE_ON: begin
          work_nxt = work_r | chan_bit;
          mode_nxt = ledfl_pkg::MODE_IDLE;
        end
        ledfl_pkg::MODE_OFF: begin
          work_nxt  = work_r & ~chan_bit;
          start_nxt = 32'd0;
          mode_nxt  = ledfl_pkg::MODE_IDLE;
        end
        ledfl_pkg::MODE_FLASH: begin
          start_nxt = start_eff;
          if (due) begin
            level_nxt = ~cur_level;
            work_nxt  = cur_level ? (work_r & ~chan_bit) : (work_r | chan_bit);
            start_nxt = now_r;
            rem_nxt   = rem_dec;
            if (rem_dec == 15'd0) begin
              mode_nxt = ledfl_pkg::MODE_OFF;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.cmd_we) begin
      case (in_func)
        ledfl_pkg::FUNC_ON: begin
          mode_nxt = ledfl_pkg::MODE_ON;
        end
        ledfl_pkg::FUNC_OFF: begin
          mode_nxt = ledfl_pkg::MODE_OFF;
        end
        ledfl_pkg::FUNC_FLASH: begin
          mode_nxt   = ledfl_pkg::MODE_FLASH;
          level_nxt  = in_start_level;
          period_nxt = in_flash_period;
          rem_nxt    = rem_sat;
        end
        default: begin
        end
      endcase
    end
  end

  // Write back the selected entry
  always_ff @(posedge clk) begin
    for (int i = 0; i < ledfl_pkg::MAX_CHANNELS; i++) begin
      if (!rst_n) begin
        mode_r[i]   <= ledfl_pkg::MODE_IDLE;
        level_r[i]  <= 1'b0;
        start_r[i]  <= 32'd0;
        period_r[i] <= 15'd0;
        rem_r[i]    <= 15'd0;
      end else if (entry_we && (addr == 3'(i))) begin
        mode_r[i]   <= mode_nxt;
        level_r[i]  <= level_nxt;
        start_r[i]  <= start_nxt;
        period_r[i] <= period_nxt;
        rem_r[i]    <= rem_nxt;
      end
    end
  end

  // Latch the update beat and build the working pattern
  always_ff @(posedge clk) begin
    if (cmd.upd_start) begin
      now_r   <= in_now_ms;
      force_r <= in_force_output;
      work_r  <= shown_r;
    end else if (cmd.walk_en) begin
      work_r <= work_nxt;
    end
  end

  // Decide whether the update gives a result
  always_comb begin
    emit             = force_r || (work_r != shown_r);
    stat.finish_hold = emit && out_valid_r && out_stall;
  end

  // Commit the pattern and load the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        shown_r <= work_r;
      end
      if (cmd.finish && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && emit) begin
      out_pat_r <= work_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led_pattern = out_pat_r;

endmodule

// File: sv/eight_channel_led_flasher_core.sv
// Top level of the eight-channel LED flasher: controller plus datapath.
//
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid/in_stall    func, channel, flash_period, start_level,
//                                           repeat_count, now_ms, force_output
//  out_     output     out_valid/out_stall  led_pattern
//
// An on, off or flash beat updates its channel entry, if in range, when accepted; the
// next beat can be taken the cycle after. An update beat is accepted, then walks the
// channel entries one at a time (one shared table read/write port), then commits the pattern.
// The commit waits while a result is due and the output register is still full.
// Reset (synchronous, rst_n low) idles every channel and clears the shown pattern to all off.
module eight_channel_led_flasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [2:0]  in_channel,
  input  logic [14:0] in_flash_period,
  input  logic        in_start_level,
  input  logic [14:0] in_repeat_count,
  input  logic [31:0] in_now_ms,
  input  logic        in_force_output,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_led_pattern
);

  ledfl_pkg::ledfl_cmd_t  cmd;
  ledfl_pkg::ledfl_stat_t stat;

  ledfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  ledfl_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_func         (in_func),
    .in_channel      (in_channel),
    .in_flash_period (in_flash_period),
    .in_start_level  (in_start_level),
    .in_repeat_count (in_repeat_count),
    .in_now_ms       (in_now_ms),
    .in_force_output (in_force_output),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_led_pattern (out_led_pattern),
    .stat            (stat)
  );

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the eight-channel LED flasher core.
module tb;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_BEATS = 1680;
  localparam int SQUEEZE_AT   = 40;
  localparam int SQUEEZE_LEN  = 400;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  channel;
    logic [14:0] flash_period;
    logic        start_level;
    logic [14:0] repeat_count;
    logic [31:0] now_ms;
    logic        force_output;
  } ledfl_beat_t;

  // How a table row gets its expectation
  typedef enum logic [1:0] {
    DUE_MODEL,
    DUE_NONE,
    DUE_PATTERN
  } due_kind_t;

  typedef struct {
    ledfl_beat_t beat;
    due_kind_t   kind;
    logic [7:0]  pattern;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [2:0]  in_channel;
  logic [14:0] in_flash_period;
  logic        in_start_level;
  logic [14:0] in_repeat_count;
  logic [31:0] in_now_ms;
  logic        in_force_output;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_led_pattern;

  // Shadow channel table
  logic [1:0]  chan_mode  [ledfl_pkg::NUM_CHANNELS];
  logic        chan_level [ledfl_pkg::NUM_CHANNELS];
  logic [31:0] chan_start [ledfl_pkg::NUM_CHANNELS];
  logic [14:0] chan_period[ledfl_pkg::NUM_CHANNELS];
  logic [14:0] chan_left  [ledfl_pkg::NUM_CHANNELS];
  logic [7:0]  lit_pattern;

  logic [7:0]  pattern_due_q[$];
  plan_row_t   plan[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          patterns_seen = 0;
  bit          calm = 1'b0;

  eight_channel_led_flasher_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_channel      (in_channel),
    .in_flash_period (in_flash_period),
    .in_start_level  (in_start_level),
    .in_repeat_count (in_repeat_count),
    .in_now_ms       (in_now_ms),
    .in_force_output (in_force_output),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_led_pattern (out_led_pattern)
  );

  always #5 clk = ~clk;

  // Count cycles and give up at the limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Apply one accepted beat to the shadow table; return 1 when a pattern is due
  function automatic bit predict_pattern(input ledfl_beat_t b, output logic [7:0] pat);
    logic [7:0]  nxt;
    logic [15:0] sum;
    bit          emit;
    nxt  = lit_pattern;
    emit = 1'b0;
    if (b.func == ledfl_pkg::FUNC_UPDATE) begin
      // walk channels in order, applying pending actions and flashers
      for (int c = 0; c < ledfl_pkg::NUM_CHANNELS; c++) begin
        case (chan_mode[c])
          ledfl_pkg::MODE_ON: begin
            nxt[c]       = 1'b1;
            chan_mode[c] = ledfl_pkg::MODE_IDLE;
          end
          ledfl_pkg::MODE_OFF: begin
            nxt[c]        = 1'b0;
            chan_start[c] = '0;
            chan_mode[c]  = ledfl_pkg::MODE_IDLE;
          end
          ledfl_pkg::MODE_FLASH: begin
            if (chan_start[c] == 32'd0)
              chan_start[c] = b.now_ms;
            if (32'(b.now_ms - chan_start[c]) > {17'd0, chan_period[c]}) begin
              chan_level[c] = ~chan_level[c];
              nxt[c]        = chan_level[c];
              chan_start[c] = b.now_ms;
              if (chan_left[c] != '0)
                chan_left[c] = chan_left[c] - 15'd1;
              if (chan_left[c] == '0)
                chan_mode[c] = ledfl_pkg::MODE_OFF;
            end
          end
          default: ;
        endcase
      end
      emit        = b.force_output || (nxt != lit_pattern);
      lit_pattern = nxt;
    end else if (int'(b.channel) < ledfl_pkg::NUM_CHANNELS) begin
      case (b.func)
        ledfl_pkg::FUNC_ON:  chan_mode[b.channel] = ledfl_pkg::MODE_ON;
        ledfl_pkg::FUNC_OFF: chan_mode[b.channel] = ledfl_pkg::MODE_OFF;
        default: begin
          sum = {1'b0, chan_left[b.channel]} + {1'b0, b.repeat_count};
          chan_mode[b.channel]   = ledfl_pkg::MODE_FLASH;
          chan_level[b.channel]  = b.start_level;
          chan_period[b.channel] = b.flash_period;
          chan_left[b.channel]   = (sum > {1'b0, ledfl_pkg::CNT_MAX}) ?
                                   ledfl_pkg::CNT_MAX : sum[14:0];
        end
      endcase
    end
    pat = nxt;
    return emit;
  endfunction

  task automatic add_row(input logic [1:0] func, input logic [2:0] ch,
                         input logic [14:0] per, input logic lvl,
                         input logic [14:0] reps, input logic [31:0] now,
                         input logic frc, input due_kind_t kind,
                         input logic [7:0] pat);
    plan_row_t row;
    row.beat    = '{func, ch, per, lvl, reps, now, frc};
    row.kind    = kind;
    row.pattern = pat;
    plan.push_back(row);
  endtask

  // Offer one beat and hold it until the core takes it
  task automatic send_beat(input ledfl_beat_t b);
    in_valid        <= 1'b1;
    in_func         <= b.func;
    in_channel      <= b.channel;
    in_flash_period <= b.flash_period;
    in_start_level  <= b.start_level;
    in_repeat_count <= b.repeat_count;
    in_now_ms       <= b.now_ms;
    in_force_output <= b.force_output;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  // Drop valid for a random gap, mostly short, now and then long
  task automatic sender_gap();
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!calm) begin
      if (r >= 90)
        gap = $urandom_range(8, 40);
      else if (r >= 55)
        gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: check each taken beat, stall at random, one long hold-off
  initial begin : drain
    int         hold;
    int         r;
    bit         squeezed;
    logic [7:0] want;
    hold      = 0;
    squeezed  = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pattern_due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected pattern beat %h", out_led_pattern));
        end else begin
          want = pattern_due_q.pop_front();
          if (out_led_pattern !== want)
            report_mismatch($sformatf("led_pattern %h, want %h", out_led_pattern, want));
        end
        patterns_seen++;
      end
      if (!squeezed && patterns_seen == SQUEEZE_AT) begin
        hold     = SQUEEZE_LEN;
        squeezed = 1'b1;
      end else if (hold == 0 && !calm) begin
        r = $urandom_range(0, 99);
        if (r >= 92)
          hold = $urandom_range(10, 40);
        else if (r >= 60)
          hold = $urandom_range(1, 3);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus: directed table, then random traffic
  initial begin : feed
    ledfl_beat_t b;
    logic [7:0]  pat;
    bit          due;
    int          pick;
    logic [31:0] clock_ms;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_func         = ledfl_pkg::FUNC_ON;
    in_channel      = '0;
    in_flash_period = '0;
    in_start_level  = 1'b0;
    in_repeat_count = '0;
    in_now_ms       = '0;
    in_force_output = 1'b0;
    for (int c = 0; c < ledfl_pkg::NUM_CHANNELS; c++) begin
      chan_mode[c]   = ledfl_pkg::MODE_IDLE;
      chan_level[c]  = 1'b0;
      chan_start[c]  = '0;
      chan_period[c] = '0;
      chan_left[c]   = '0;
    end
    lit_pattern = '0;

    // after reset, forced update shows all off, plain update shows nothing
    add_row(ledfl_pkg::FUNC_UPDATE, 3'd0, 15'd0, 1'b0, 15'd0, 32'd1000, 1'b1,
            DUE_PATTERN, 8'h00);
    add_row(ledfl_pkg::FUNC_UPDATE, 3'd0, 15'd0, 1'b0, 15'd0, 32'd1001, 1'b0,
            DUE_NONE, 8'h00);
    // on at both ends of the channel range, off at the low end
    add_row(ledfl_pkg::FUNC_ON, 3'd0, 15'd0, 1'b0, 15'd0, 32'd0, 1'b0,
            DUE_NONE, 8'h00);
    add_row(ledfl_pkg::FUNC_ON, 3'd7, 15'd0, 1'b0, 15'd0, 32'd0, 1'b0,
            DUE_NONE, 8'h00);
    add_row(ledfl_pkg::FUNC_UPDATE, 3'd0, 15'd0, 1'b0, 15'd0, 32'd1002, 1'b0,
            DUE_PATTERN, 8'h81);
    add_row(ledfl_pkg::FUNC_OFF, 3'd0, 15'd0, 1'b0, 15'd0, 32'd0, 1'b0,
            DUE_NONE, 8'h00);
    add_row(ledfl_pkg::FUNC_UPDATE, 3'd0, 15'd0, 1'b0, 15'd0, 32'd1003, 1'b0,
            DUE_PATTERN, 8'h80);
    // zero repeat count: one toggle, then off
    add_row(ledfl_pkg::FUNC_FLASH, 3'd3, 15'd0, 1'b0, 15'd0, 32'd0, 1'b0,
            DUE_NONE, 8'h00);
    add_row(ledfl_pkg::FUNC_UPDATE, 3'd0, 15'd0, 1'b0, 15'd0, 32'd5, 1'b0,
            DUE_NONE, 8'h00);
    add_row(ledfl_pkg::FUNC_UPDATE, 3'd0, 15'd0, 1'b0, 15'd0, 32'd6, 1'b0,
            DUE_PATTERN, 8'h88);
    add_row(ledfl_pkg::FUNC_UPDATE, 3'd0, 15'd0, 1'b0, 15'd0, 32'd7, 1'b0,
            DUE_PATTERN, 8'h80);
    // longest period, repeat count saturating
    add_row(ledfl_pkg::FUNC_FLASH, 3'd2, 15'h7FFF, 1'b1, 15'h7FFF, 32'd0, 1'b0,
            DUE_NONE, 8'h00);
    add_row(ledfl_pkg::FUNC_FLASH, 3'd2, 15'h7FFF, 1'b1, 15'h7FFF, 32'd0, 1'b0,
            DUE_NONE, 8'h00);
    add_row(ledfl_pkg::FUNC_UPDATE, 3'd0, 15'd0, 1'b0, 15'd0, 32'hFFFF_FFF0, 1'b1,
            DUE_PATTERN, 8'h80);
    // elapsed time wrapping past 2^32
    add_row(ledfl_pkg::FUNC_UPDATE, 3'd0, 15'd0, 1'b0, 15'd0, 32'h0000_7FF0, 1'b0,
            DUE_MODEL, 8'h00);
    // toggle landing at time zero clears the start time
    add_row(ledfl_pkg::FUNC_FLASH, 3'd5, 15'd0, 1'b1, 15'd2, 32'd0, 1'b0,
            DUE_NONE, 8'h00);
    add_row(ledfl_pkg::FUNC_UPDATE, 3'd0, 15'd0, 1'b0, 15'd0, 32'hFFFF_FFFF, 1'b0,
            DUE_MODEL, 8'h00);
    add_row(ledfl_pkg::FUNC_UPDATE, 3'd0, 15'd0, 1'b0, 15'd0, 32'd0, 1'b0,
            DUE_MODEL, 8'h00);
    add_row(ledfl_pkg::FUNC_UPDATE, 3'd0, 15'd0, 1'b0, 15'd0, 32'd10, 1'b0,
            DUE_MODEL, 8'h00);
    add_row(ledfl_pkg::FUNC_UPDATE, 3'd0, 15'd0, 1'b0, 15'd0, 32'd12, 1'b0,
            DUE_MODEL, 8'h00);
    add_row(ledfl_pkg::FUNC_ON, 3'd4, 15'h7FFF, 1'b1, 15'h7FFF, 32'hFFFF_FFFF, 1'b1,
            DUE_NONE, 8'h00);
    // all fields at their top value
    add_row(ledfl_pkg::FUNC_UPDATE, 3'd7, 15'h7FFF, 1'b1, 15'h7FFF, 32'hFFFF_FFFF,
            1'b1, DUE_MODEL, 8'h00);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    foreach (plan[i]) begin
      send_beat(plan[i].beat);
      due = predict_pattern(plan[i].beat, pat);
      case (plan[i].kind)
        DUE_PATTERN: pattern_due_q.push_back(plan[i].pattern);
        DUE_MODEL:   if (due) pattern_due_q.push_back(pat);
        default: ;
      endcase
      sender_gap();
    end

    // random traffic: on, off and flash set-ups interleaved with updates on an advancing clock that now and then jumps
    clock_ms = 32'd20;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 150 == 0)
        calm <= ($urandom_range(0, 3) == 0);
      b.channel      = 3'($urandom_range(0, 7));
      b.flash_period = 15'($urandom);
      b.start_level  = 1'($urandom);
      b.repeat_count = 15'($urandom);
      b.now_ms       = $urandom;
      b.force_output = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        b.func = ledfl_pkg::FUNC_ON;
      end else if (pick < 22) begin
        b.func = ledfl_pkg::FUNC_OFF;
      end else if (pick < 48) begin
        b.func = ledfl_pkg::FUNC_FLASH;
        if ($urandom_range(0, 19) != 0)
          b.flash_period = 15'($urandom_range(0, 8));
        if ($urandom_range(0, 19) != 0)
          b.repeat_count = 15'($urandom_range(0, 6));
      end else begin
        b.func = ledfl_pkg::FUNC_UPDATE;
        pick   = $urandom_range(0, 99);
        if (pick < 3)
          clock_ms = $urandom;
        else if (pick < 5)
          clock_ms = 32'd0;
        else if (pick < 10)
          clock_ms = clock_ms + $urandom_range(0, 70000);
        else
          clock_ms = clock_ms + $urandom_range(0, 6);
        b.now_ms       = clock_ms;
        b.force_output = ($urandom_range(0, 99) < 15);
      end
      send_beat(b);
      if (predict_pattern(b, pat))
        pattern_due_q.push_back(pat);
      sender_gap();
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    // wait out every due pattern, then watch for strays
    while (pattern_due_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
